[hdl/csps_pkg.sv]
// ----------------------------------------------------------------------------
// csps_pkg
// Shared types and constants of the cubic spline point sampler: field widths,
// request and basis codes, register indexes and the fixed-point reciprocal.
// ----------------------------------------------------------------------------
package csps_pkg;

    // field widths
    localparam int unsigned COORD_W = 32;
    localparam int unsigned POINT_W = 3 * COORD_W;
    localparam int unsigned PARAM_W = 26;
    localparam int unsigned INDEX_W = 10;
    localparam int unsigned COUNT_W = 11;

    // configuration port
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 3;
    localparam logic [0:0]  REG_POINT_COUNT = 1'b0;
    localparam logic [0:0]  REG_BASIS_MODE  = 1'b1;

    // pipeline depth, query accept to result register
    localparam int unsigned STAGES = 8;
    typedef logic [STAGES-1:0] t_stage_en;

    // 1/6 in Q0.32
    localparam logic signed [31:0] RECIP6_Q32 = 32'sd715827883;

    // saturation limits
    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef enum logic {
        REQ_STORE = 1'b0,
        REQ_EVAL  = 1'b1
    } t_req;

    typedef enum logic {
        BASIS_BSPLINE = 1'b0,
        BASIS_CATROM  = 1'b1
    } t_basis;

endpackage

[hdl/csps_mem.sv]
// ----------------------------------------------------------------------------
// csps_mem
// Control point memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module csps_mem #(
    parameter int unsigned DEPTH  = 1024,
    parameter int unsigned ADDR_W = 10,
    parameter int unsigned DATA_W = 96
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/csps_weight.sv]
// ----------------------------------------------------------------------------
// csps_weight
// Basis weight pipeline: u squared, u cubed, basis polynomials, and the
// rounded division by six for the B-spline basis. Four stages.
// ----------------------------------------------------------------------------
module csps_weight
    import csps_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic [3:0]                    i_en,
    input  logic [FRAC_BITS-1:0]          i_u,
    input  t_basis                        i_basis_mode,
    output logic signed [FRAC_BITS+3:0]   o_weight [4]
);

    localparam int unsigned WW  = FRAC_BITS + 4;
    localparam int unsigned SQW = 2 * FRAC_BITS;
    localparam int unsigned PRW = WW + 32;

    localparam logic [SQW-1:0]        HALF    = SQW'(1) << (FRAC_BITS - 1);
    localparam logic signed [WW-1:0]  ONE     = WW'(1) << FRAC_BITS;
    localparam logic signed [WW-1:0]  K2      = WW'(2);
    localparam logic signed [WW-1:0]  K3      = WW'(3);
    localparam logic signed [WW-1:0]  K4      = WW'(4);
    localparam logic signed [WW-1:0]  K5      = WW'(5);
    localparam logic signed [WW-1:0]  K6      = WW'(6);
    localparam logic signed [PRW-1:0] ROUND32 = PRW'(1) << 31;

    logic [FRAC_BITS-1:0]   r1_u, r1_uu;
    logic [FRAC_BITS-1:0]   r2_u, r2_uu, r2_uuu;
    logic signed [WW-1:0]   r3_coef [4];
    logic signed [WW-1:0]   r4_weight [4];

    logic [SQW-1:0]         sq, cube;
    logic signed [WW-1:0]   eu, euu, euuu;
    logic signed [WW-1:0]   n_coef [4];
    logic signed [PRW-1:0]  scaled [4];
    logic signed [WW-1:0]   n_weight [4];

    // stage 1: rounded u squared
    assign sq = SQW'(i_u) * SQW'(i_u) + HALF;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_u  <= i_u;
            r1_uu <= sq[SQW-1:FRAC_BITS];
        end
    end

    // stage 2: rounded u cubed
    assign cube = SQW'(r1_uu) * SQW'(r1_u) + HALF;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r2_u   <= r1_u;
            r2_uu  <= r1_uu;
            r2_uuu <= cube[SQW-1:FRAC_BITS];
        end
    end

    // stage 3: basis polynomials, six times or two times the weights
    assign eu   = signed'({4'b0, r2_u});
    assign euu  = signed'({4'b0, r2_uu});
    assign euuu = signed'({4'b0, r2_uuu});

    always_comb begin
        unique case (i_basis_mode)
            BASIS_BSPLINE: begin
                n_coef[0] = ONE - K3 * eu + K3 * euu - euuu;
                n_coef[1] = K4 * ONE - K6 * euu + K3 * euuu;
                n_coef[2] = ONE + K3 * eu + K3 * euu - K3 * euuu;
                n_coef[3] = euuu;
            end
            BASIS_CATROM: begin
                n_coef[0] = K2 * euu - euuu - eu;
                n_coef[1] = K3 * euuu - K5 * euu + K2 * ONE;
                n_coef[2] = K4 * euu - K3 * euuu + eu;
                n_coef[3] = euuu - euu;
            end
            default: begin
                n_coef[0] = '0;
                n_coef[1] = '0;
                n_coef[2] = '0;
                n_coef[3] = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r3_coef <= n_coef;
        end
    end

    // stage 4: divide by six through the Q0.32 reciprocal, rounded (B-spline only)
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            scaled[k] = r3_coef[k] * RECIP6_Q32 + ROUND32;
            if (i_basis_mode == BASIS_BSPLINE) begin
                n_weight[k] = scaled[k][PRW-1:32];
            end else begin
                n_weight[k] = r3_coef[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r4_weight <= n_weight;
        end
    end

    assign o_weight = r4_weight;

endmodule

[hdl/csps_blend.sv]
// ----------------------------------------------------------------------------
// csps_blend
// One coordinate of the blend: four point-by-weight products, a two-level
// adder, final rounding shift and saturation. Four stages.
// ----------------------------------------------------------------------------
module csps_blend
    import csps_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic [3:0]                  i_en,
    input  t_basis                      i_basis_mode,
    input  logic signed [COORD_W-1:0]   i_point [4],
    input  logic signed [FRAC_BITS+3:0] i_weight [4],
    output logic signed [COORD_W-1:0]   o_coord
);

    localparam int unsigned WW    = FRAC_BITS + 4;
    localparam int unsigned PRODW = COORD_W + WW;
    localparam int unsigned ACCW  = PRODW + 2;

    localparam logic signed [ACCW-1:0] RND_BSPLINE = ACCW'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACCW-1:0] RND_CATROM  = ACCW'(1) << FRAC_BITS;

    logic signed [PRODW-1:0]   r5_prod [4];
    logic signed [ACCW-1:0]    r6_pair [2];
    logic signed [ACCW-1:0]    r7_acc;
    logic signed [COORD_W-1:0] r8_coord;

    logic signed [PRODW-1:0]   n_prod [4];
    logic signed [ACCW-1:0]    rnd;
    logic signed [ACCW-1:0]    shifted;
    logic                      fits;
    logic signed [COORD_W-1:0] n_coord;

    // stage 5: products
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_prod[k] = PRODW'(i_point[k]) * PRODW'(i_weight[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r5_prod <= n_prod;
        end
    end

    // stage 6: pairwise sums
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r6_pair[0] <= ACCW'(r5_prod[0]) + ACCW'(r5_prod[1]);
            r6_pair[1] <= ACCW'(r5_prod[2]) + ACCW'(r5_prod[3]);
        end
    end

    // stage 7: total plus rounding offset
    assign rnd = (i_basis_mode == BASIS_CATROM) ? RND_CATROM : RND_BSPLINE;

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r7_acc <= r6_pair[0] + r6_pair[1] + rnd;
        end
    end

    // stage 8: floor shift and saturation
    always_comb begin
        if (i_basis_mode == BASIS_CATROM) begin
            shifted = r7_acc >>> (FRAC_BITS + 1);
        end else begin
            shifted = r7_acc >>> FRAC_BITS;
        end
        fits = (&shifted[ACCW-1:COORD_W-1]) || !(|shifted[ACCW-1:COORD_W-1]);
        priority if (fits) begin
            n_coord = shifted[COORD_W-1:0];
        end else if (shifted[ACCW-1]) begin
            n_coord = COORD_MIN;
        end else begin
            n_coord = COORD_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r8_coord <= n_coord;
        end
    end

    assign o_coord = r8_coord;

endmodule

[hdl/cubic_spline_point_sampler.sv]
// ----------------------------------------------------------------------------
// cubic_spline_point_sampler
// Stores 3D control points and evaluates a uniform cubic B-spline or a
// Catmull-Rom curve at a fixed-point parameter.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle while o_ready is high,
// stores and queries alike. A store writes its point into the table at the
// edge where it is accepted and gives no result; a query issued right after
// it already sees the new point. A query runs through an eight-stage
// pipeline (memory read with u squared, u cubed, basis polynomials, division
// by six, products, two adder levels folded with rounding, shift and
// saturation), and its result waits in the last stage until the output
// takes it. The table is kept in four copies that are written together, one
// read port each, which gives the four neighbour reads of a query in the
// same cycle. o_ready falls only when all eight stages hold queries and the
// output is stalled. Registers: point_count at byte address 0, basis_mode
// at 4; write them only while no query is in flight. Reading a table slot
// that was never written returns undefined coordinates.
// ----------------------------------------------------------------------------
module cubic_spline_point_sampler
    import csps_pkg::*;
#(
    parameter int unsigned MAX_POINTS = 1024,
    parameter int unsigned FRAC_BITS  = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_W-1:0]     paddr,
    input  logic [APB_DATA_W-1:0]     pwdata,
    output logic [APB_DATA_W-1:0]     prdata,
    output logic                      pready,
    // request channel
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_req_type,
    input  logic [INDEX_W-1:0]        i_point_index,
    input  logic signed [COORD_W-1:0] i_point_x,
    input  logic signed [COORD_W-1:0] i_point_y,
    input  logic signed [COORD_W-1:0] i_point_z,
    input  logic [PARAM_W-1:0]        i_curve_param,
    // result channel
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [COORD_W-1:0] o_curve_x,
    output logic signed [COORD_W-1:0] o_curve_y,
    output logic signed [COORD_W-1:0] o_curve_z
);

    localparam int unsigned AW   = $clog2(MAX_POINTS);
    localparam int unsigned WW   = FRAC_BITS + 4;
    localparam int unsigned SEGW = PARAM_W - FRAC_BITS;
    localparam int unsigned M1   = (SEGW > COUNT_W) ? SEGW : COUNT_W;
    localparam int unsigned M2   = (M1 > AW + 1) ? M1 : AW + 1;
    localparam int unsigned CW   = M2 + 2;

    localparam logic signed [CW-1:0] MAX_S = CW'(MAX_POINTS);

    // configuration registers
    logic [COUNT_W-1:0]   r_point_count;
    logic [AW-1:0]        r_last;
    t_basis               r_basis_mode;
    logic [AW-1:0]        n_last;
    logic                 cfg_wr;
    logic signed [CW-1:0] cnt_s;

    // pipeline control
    logic [STAGES-1:0]    r_v;
    t_stage_en            en;
    logic                 accept;
    logic                 store_we;

    // address generation
    logic signed [CW-1:0] seg_s;
    logic signed [CW-1:0] last_s;
    logic signed [CW-1:0] idx_s;
    logic signed [CW-1:0] cand [4];
    logic [AW-1:0]        rd_addr [4];

    // point data
    logic [POINT_W-1:0]   mem_rdata [4];
    logic [POINT_W-1:0]   r2_pts [4];
    logic [POINT_W-1:0]   r3_pts [4];
    logic [POINT_W-1:0]   r4_pts [4];

    logic signed [WW-1:0]      weight [4];
    logic signed [COORD_W-1:0] coord_res [3];

    // register writes, with the clamp bound worked out once
    assign cfg_wr = psel && penable && pwrite && pready;
    assign cnt_s  = signed'({{(CW-COUNT_W){1'b0}}, pwdata[COUNT_W-1:0]});

    always_comb begin
        priority if (cnt_s == '0) begin
            n_last = '0;
        end else if (cnt_s > MAX_S) begin
            n_last = AW'(MAX_POINTS - 1);
        end else begin
            n_last = AW'(cnt_s - CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= COUNT_W'(1);
            r_last        <= '0;
            r_basis_mode  <= BASIS_BSPLINE;
        end else if (cfg_wr) begin
            unique case (paddr[2:2])
                REG_POINT_COUNT: begin
                    r_point_count <= pwdata[COUNT_W-1:0];
                    r_last        <= n_last;
                end
                REG_BASIS_MODE: begin
                    r_basis_mode <= t_basis'(pwdata[0]);
                end
                default: begin
                    r_basis_mode <= r_basis_mode;
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (paddr[2:2])
            REG_POINT_COUNT: prdata = {{(APB_DATA_W-COUNT_W){1'b0}}, r_point_count};
            REG_BASIS_MODE:  prdata = {{(APB_DATA_W-1){1'b0}}, 1'(r_basis_mode)};
            default:         prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // stage enables: a stage loads when it is empty or the next one moves
    always_comb begin
        en[STAGES-1] = !r_v[STAGES-1] || i_ready;
        for (int s = STAGES - 2; s >= 0; s--) begin
            en[s] = !r_v[s] || en[s+1];
        end
    end

    assign o_ready = en[0];
    assign accept  = i_valid && o_ready;

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= accept && (i_req_type == REQ_EVAL);
            end
            for (int s = 1; s < STAGES; s++) begin
                if (en[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    // store transaction: write all four copies when the slot exists
    assign idx_s    = signed'({{(CW-INDEX_W){1'b0}}, i_point_index});
    assign store_we = accept && (i_req_type == REQ_STORE) && (idx_s < MAX_S);

    // neighbour indices, each clamped to the valid range
    assign seg_s  = signed'({{(CW-SEGW){1'b0}}, i_curve_param[PARAM_W-1:FRAC_BITS]});
    assign last_s = signed'({{(CW-AW){1'b0}}, r_last});

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            cand[k] = seg_s - CW'(1) + CW'(k);
            priority if (cand[k][CW-1]) begin
                rd_addr[k] = '0;
            end else if (cand[k] > last_s) begin
                rd_addr[k] = r_last;
            end else begin
                rd_addr[k] = cand[k][AW-1:0];
            end
        end
    end

    // point table copies, read at stage 1
    for (genvar g = 0; g < 4; g++) begin : g_mem
        csps_mem #(
            .DEPTH  (MAX_POINTS),
            .ADDR_W (AW),
            .DATA_W (POINT_W)
        ) u_mem (
            .i_clk   (i_clk),
            .i_we    (store_we),
            .i_waddr (idx_s[AW-1:0]),
            .i_wdata ({i_point_z, i_point_y, i_point_x}),
            .i_re    (en[0]),
            .i_raddr (rd_addr[g]),
            .o_rdata (mem_rdata[g])
        );
    end

    // points wait alongside the weight pipeline
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r2_pts <= mem_rdata;
        end
        if (en[2]) begin
            r3_pts <= r2_pts;
        end
        if (en[3]) begin
            r4_pts <= r3_pts;
        end
    end

    // weights, stages 1 to 4
    csps_weight #(
        .FRAC_BITS (FRAC_BITS)
    ) u_weight (
        .i_clk        (i_clk),
        .i_en         (en[3:0]),
        .i_u          (i_curve_param[FRAC_BITS-1:0]),
        .i_basis_mode (r_basis_mode),
        .o_weight     (weight)
    );

    // blend per coordinate, stages 5 to 8
    for (genvar c = 0; c < 3; c++) begin : g_coord
        logic signed [COORD_W-1:0] coord_pt [4];

        always_comb begin
            for (int k = 0; k < 4; k++) begin
                coord_pt[k] = signed'(r4_pts[k][c*COORD_W +: COORD_W]);
            end
        end

        csps_blend #(
            .FRAC_BITS (FRAC_BITS)
        ) u_blend (
            .i_clk        (i_clk),
            .i_en         (en[7:4]),
            .i_basis_mode (r_basis_mode),
            .i_point      (coord_pt),
            .i_weight     (weight),
            .o_coord      (coord_res[c])
        );
    end

    assign o_valid   = r_v[STAGES-1];
    assign o_curve_x = coord_res[0];
    assign o_curve_y = coord_res[1];
    assign o_curve_z = coord_res[2];

    // a store transaction never occupies a pipeline slot
    a_store_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_req_type == REQ_STORE) |=> !r_v[0])
        else $error("store transaction entered the pipeline");

    // an accepted query always lands in stage 1
    a_query_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_req_type == REQ_EVAL) |=> r_v[0])
        else $error("accepted query lost at stage 1");

    // backpressure only with every stage occupied
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (&r_v))
        else $error("ready low with an empty stage");

endmodule
